/* sv/u16u8_pkg.sv */
// Shared types, constants and encoding helpers for the UTF-16LE to UTF-8 transcoder.
// No dependencies; imported by the transcoder and its checker.
package u16u8_pkg;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

    localparam int BUF_BYTES = 6;
    localparam int CNT_W     = $clog2(BUF_BYTES + 1);
    localparam int IDX_W     = $clog2(BUF_BYTES);

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } in_word_t;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       run_last;
        logic       string_end;
    } out_word_t;

    // Up to three bytes of one BMP code point, element 0 leaves first.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      len;
    } bmp_seq_t;

    function automatic logic is_high(input logic [15:0] u);
        return u inside {[HIGH_FIRST:HIGH_LAST]};
    endfunction

    function automatic logic is_low(input logic [15:0] u);
        return u inside {[LOW_FIRST:LOW_LAST]};
    endfunction

    function automatic bmp_seq_t encode_bmp(input logic [15:0] u);
        bmp_seq_t s;
        s = '0;
        if (u < ONE_BYTE_LIMIT)
        begin
            s.bytes[0] = {1'b0, u[6:0]};
            s.len      = 2'd1;
        end
        else if (u < TWO_BYTE_LIMIT)
        begin
            s.bytes[0] = {3'b110, u[10:6]};
            s.bytes[1] = {2'b10, u[5:0]};
            s.len      = 2'd2;
        end
        else
        begin
            s.bytes[0] = {4'b1110, u[15:12]};
            s.bytes[1] = {2'b10, u[11:6]};
            s.bytes[2] = {2'b10, u[5:0]};
            s.len      = 2'd3;
        end
        return s;
    endfunction

endpackage

/* sv/utf16le_to_utf8_transcoder.sv */
// UTF-16LE code unit to UTF-8 byte stream transcoder, top level.
// Depends on u16u8_pkg for the word types and the BMP encoder.

// One 16-bit code unit enters per input word and leaves as zero to six UTF-8
// bytes, one byte per output word. A code unit is taken every cycle as long as
// the byte buffer is empty or hands out its last byte: an item holds one to
// three bytes for BMP units, four for a surrogate pair, none for a held high
// surrogate and up to six when a held high surrogate is flushed ahead of a new
// unit, so the emitted bytes, not the code units, set the sustained rate. A
// unit passes an input register, is encoded in one pass and loaded into a
// six-byte output buffer, which is what sets the throughput. Unpaired
// surrogates are emitted as three-byte sequences.
module utf16le_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic                           s1_valid_reg;
    in_word_t                       s1_word_reg;
    logic                           held_valid_reg, held_valid_next;
    logic [9:0]                     held_bits_reg, held_bits_next;
    logic [BUF_BYTES-1:0][7:0]      buf_reg, buf_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [IDX_W-1:0]               idx_reg;
    logic                           last_reg;

    logic       buf_free;
    logic       s1_move;
    logic       unit_high;
    logic       unit_low;
    bmp_seq_t   unit_seq;
    bmp_seq_t   held_seq;
    logic [4:0] plane;

    assign out_valid = (cnt_reg != '0);
    assign buf_free  = (cnt_reg == '0) ||
                       ((cnt_reg == CNT_W'(1)) && out_ready);
    assign s1_move   = s1_valid_reg && buf_free;
    assign in_ready  = !s1_valid_reg || buf_free;

    assign out_word.utf8_byte  = buf_reg[idx_reg];
    assign out_word.run_last   = (cnt_reg == CNT_W'(1));
    assign out_word.string_end = (cnt_reg == CNT_W'(1)) && last_reg;

    assign unit_high = is_high(s1_word_reg.code_unit);
    assign unit_low  = is_low(s1_word_reg.code_unit);
    assign unit_seq  = encode_bmp(s1_word_reg.code_unit);
    assign held_seq  = encode_bmp({6'b110110, held_bits_reg});
    assign plane     = {1'b0, held_bits_reg[9:6]} + 5'd1;

    always_comb
    begin
        buf_next        = '0;
        cnt_next        = '0;
        held_valid_next = unit_high && !s1_word_reg.last_unit;
        held_bits_next  = held_valid_next ? s1_word_reg.code_unit[9:0] : 10'd0;
        if (held_valid_reg && unit_low)
        begin
            // Pair: code point is 0x10000 plus the twenty payload bits.
            buf_next[0] = {5'b11110, plane[4:2]};
            buf_next[1] = {2'b10, plane[1:0], held_bits_reg[5:2]};
            buf_next[2] = {2'b10, held_bits_reg[1:0], s1_word_reg.code_unit[9:6]};
            buf_next[3] = {2'b10, s1_word_reg.code_unit[5:0]};
            cnt_next    = CNT_W'(4);
        end
        else if (held_valid_reg)
        begin
            buf_next[0] = held_seq.bytes[0];
            buf_next[1] = held_seq.bytes[1];
            buf_next[2] = held_seq.bytes[2];
            cnt_next    = CNT_W'(3);
            if (!held_valid_next)
            begin
                buf_next[3] = unit_seq.bytes[0];
                buf_next[4] = unit_seq.bytes[1];
                buf_next[5] = unit_seq.bytes[2];
                cnt_next    = CNT_W'(3) + CNT_W'(unit_seq.len);
            end
        end
        else if (!held_valid_next)
        begin
            buf_next[0] = unit_seq.bytes[0];
            buf_next[1] = unit_seq.bytes[1];
            buf_next[2] = unit_seq.bytes[2];
            cnt_next    = CNT_W'(unit_seq.len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_move)
            begin
                held_valid_reg <= held_valid_next;
                held_bits_reg  <= held_bits_next;
                cnt_reg        <= cnt_next;
                idx_reg        <= '0;
            end
            else if (out_valid && out_ready)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_word_reg <= in_word;
        end
        if (s1_move)
        begin
            buf_reg  <= buf_next;
            last_reg <= s1_word_reg.last_unit;
        end
    end

endmodule

/* sv/u16u8_checker.sv */
// Port-level checker for the UTF-16LE to UTF-8 transcoder, bound to the top level.
// Depends on u16u8_pkg for the word types.
module u16u8_checker
    import u16u8_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_word,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // A waiting input word holds until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_word))
        else $error("input word changed while waiting");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // The end of the string always closes the bytes of its unit.
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.string_end |-> out_word.run_last)
        else $error("string_end without run_last");

    // Remaining bytes of a unit are already buffered, so no gap follows.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_word.run_last |=> out_valid)
        else $error("gap inside the bytes of one unit");

    // Only the last byte of a unit can be ASCII; the others are lead or
    // continuation bytes.
    a_inner_not_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.run_last |-> out_word.utf8_byte[7])
        else $error("ASCII byte inside a multi-byte run");

endmodule

bind utf16le_to_utf8_transcoder u16u8_checker u_checker (.*);
